// ===== rtl/transaction_write_set_buffer_assert.svh =====
// Assertion macros used by the controller RTL.
`ifndef TRANSACTION_WRITE_SET_BUFFER_ASSERT_SVH
`define TRANSACTION_WRITE_SET_BUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TWSB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define TWSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/twsb_pkg.sv =====
package twsb_pkg;

   localparam int DEPTH_DEFAULT        = 32;
   localparam int NUM_CONTEXTS_DEFAULT = 4;
   localparam int MAX_RESULTS          = 32;

   // Request codes.
   localparam logic [2:0] REQ_APPEND = 3'd0;
   localparam logic [2:0] REQ_LOOKUP = 3'd1;
   localparam logic [2:0] REQ_SORT   = 3'd2;
   localparam logic [2:0] REQ_CLEAR  = 3'd3;
   localparam logic [2:0] REQ_DRAIN  = 3'd4;

   // Result status codes.
   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_DELETED   = 3'd3;
   localparam logic [2:0] ST_FOUND     = 3'd4;
   localparam logic [2:0] ST_DRAINED   = 3'd5;
   localparam logic [2:0] ST_EMPTY     = 3'd6;

   localparam logic [1:0] KIND_DELETE = 2'd2;

   // Write data source.
   localparam logic [1:0] WR_REQ  = 2'd0;
   localparam logic [1:0] WR_HOLD = 2'd1;
   localparam logic [1:0] WR_RD   = 2'd2;

   // Read address source.
   localparam logic RD_IDX = 1'b0;
   localparam logic RD_JM1 = 1'b1;

   // Index register operations.
   localparam logic [2:0] IDX_HOLD = 3'd0;
   localparam logic [2:0] IDX_LOOK = 3'd1;
   localparam logic [2:0] IDX_ZERO = 3'd2;
   localparam logic [2:0] IDX_ONE  = 3'd3;
   localparam logic [2:0] IDX_DEC  = 3'd4;
   localparam logic [2:0] IDX_INC  = 3'd5;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [1:0]  context_req;
      logic [1:0]  rec_kind;
      logic [7:0]  table_num;
      logic [31:0] tuple_num;
      logic [31:0] rec_value;
      logic [31:0] slot;
      logic [5:0]  drain_count;
      logic        drain_all;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_value;
      logic [1:0]  out_kind;
      logic [7:0]  out_table;
      logic [31:0] out_tuple;
      logic [31:0] out_slot;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [39:0] key;
      logic [31:0] value;
      logic [31:0] slot;
   } entry_type;

   typedef struct packed {
      logic       load_req;
      logic       wr_en;
      logic [1:0] wr_src;
      logic       cnt_inc;
      logic       cnt_clr;
      logic       rd_en;
      logic       rd_sel;
      logic [2:0] idx_op;
      logic       hold_load;
      logic       j_load;
      logic       j_dec;
      logic       rsp_load;
      logic [2:0] rsp_status;
      logic       rsp_last;
   } twsb_cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       ctx_ok;
      logic       full;
      logic       cnt_zero;
      logic       cnt_lt2;
      logic       drain_zero;
      logic       idx_zero;
      logic       drain_last;
      logic       sort_last;
      logic       j_zero;
      logic       key_hit;
      logic       hit_deleted;
      logic       key_gt;
      logic       rsp_free;
   } twsb_sts_type;

endpackage

// ===== rtl/transaction_write_set_buffer.sv =====
// Transaction write-set buffer: one table of DEPTH records per context, held in a
// single-port-write, single-port-read memory and walked one entry at a time. Append
// and clear go from dispatch straight to the result state, as do an unknown request
// and an out-of-range context. Lookup reads newest-first, one entry per visit, so up
// to DEPTH entries are read. Drain emits one entry per read while the result side
// keeps up. Sort is a stable insertion sort: each element is read and held, and the
// entries before it whose key is greater are shifted up one place; the one memory
// port pair paces all of these. One request is worked on at a time, and a new one
// is taken once the last result is in the output register, even if that result has
// not yet been taken.
module transaction_write_set_buffer
   import twsb_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   // Commands from the controller and status back from the datapath.
   twsb_cmd_type cmd;
   twsb_sts_type sts;

   twsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the entry memory, the per-context fill counts and the
   // result register.
   twsb_datapath #(
      .DEPTH        (DEPTH),
      .NUM_CONTEXTS (NUM_CONTEXTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== rtl/twsb_ctrl.sv =====
`include "transaction_write_set_buffer_assert.svh"

module twsb_ctrl
   import twsb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  twsb_sts_type sts,
   output twsb_cmd_type cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DISP    = 4'd1;
   localparam logic [3:0] S_LK_RD   = 4'd2;
   localparam logic [3:0] S_LK_CMP  = 4'd3;
   localparam logic [3:0] S_SO_RDI  = 4'd4;
   localparam logic [3:0] S_SO_HOLD = 4'd5;
   localparam logic [3:0] S_SO_RDJ  = 4'd6;
   localparam logic [3:0] S_SO_CMP  = 4'd7;
   localparam logic [3:0] S_SO_NEXT = 4'd8;
   localparam logic [3:0] S_DR_RD   = 4'd9;
   localparam logic [3:0] S_DR_OUT  = 4'd10;
   localparam logic [3:0] S_RESP    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [2:0] stat_ff, stat_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      stat_in  = stat_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_RESP;
            case (sts.req_type)
               REQ_APPEND: begin
                  if (sts.ctx_ok && !sts.full) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_src  = WR_REQ;
                     cmd.cnt_inc = 1'b1;
                     stat_in     = ST_DONE;
                  end else begin
                     stat_in = ST_FULL;
                  end
               end
               REQ_LOOKUP: begin
                  if (!sts.ctx_ok || sts.cnt_zero) begin
                     stat_in = ST_NOT_FOUND;
                  end else begin
                     cmd.idx_op = IDX_LOOK;
                     state_in   = S_LK_RD;
                  end
               end
               REQ_SORT: begin
                  if (!sts.ctx_ok || sts.cnt_lt2) begin
                     stat_in = ST_DONE;
                  end else begin
                     cmd.idx_op = IDX_ONE;
                     state_in   = S_SO_RDI;
                  end
               end
               REQ_CLEAR: begin
                  cmd.cnt_clr = sts.ctx_ok;
                  stat_in     = ST_DONE;
               end
               REQ_DRAIN: begin
                  if (sts.drain_zero) begin
                     stat_in = ST_EMPTY;
                  end else begin
                     cmd.idx_op = IDX_ZERO;
                     state_in   = S_DR_RD;
                  end
               end
               default: begin
                  stat_in = ST_DONE;
               end
            endcase
         end
         S_LK_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_LK_CMP;
         end
         S_LK_CMP: begin
            if (sts.key_hit) begin
               stat_in  = sts.hit_deleted ? ST_DELETED : ST_FOUND;
               state_in = S_RESP;
            end else if (sts.idx_zero) begin
               stat_in  = ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               cmd.idx_op = IDX_DEC;
               state_in   = S_LK_RD;
            end
         end
         S_SO_RDI: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_SO_HOLD;
         end
         S_SO_HOLD: begin
            cmd.hold_load = 1'b1;
            cmd.j_load    = 1'b1;
            state_in      = S_SO_RDJ;
         end
         S_SO_RDJ: begin
            if (sts.j_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = WR_HOLD;
               state_in   = S_SO_NEXT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_JM1;
               state_in   = S_SO_CMP;
            end
         end
         S_SO_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.key_gt) begin
               cmd.wr_src = WR_RD;
               cmd.j_dec  = 1'b1;
               state_in   = S_SO_RDJ;
            end else begin
               cmd.wr_src = WR_HOLD;
               state_in   = S_SO_NEXT;
            end
         end
         S_SO_NEXT: begin
            if (sts.sort_last) begin
               stat_in  = ST_DONE;
               state_in = S_RESP;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SO_RDI;
            end
         end
         S_DR_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_DR_OUT;
         end
         S_DR_OUT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_DRAINED;
               cmd.rsp_last   = sts.drain_last;
               if (sts.drain_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_op = IDX_INC;
                  state_in   = S_DR_RD;
               end
            end
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = stat_ff;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      stat_ff <= stat_in;
   end

   `TWSB_ASSERT_NOW(a_load_when_free, clock, reset, cmd.rsp_load, sts.rsp_free)
   `TWSB_ASSERT_NOW(a_write_valid_ctx, clock, reset, cmd.wr_en, sts.ctx_ok)
   `TWSB_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && req_ready, state_ff == S_DISP)

endmodule

// ===== rtl/twsb_datapath.sv =====
module twsb_datapath
   import twsb_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  twsb_cmd_type    cmd,
   output twsb_sts_type    sts
);

   localparam int ENTRIES = NUM_CONTEXTS * DEPTH;
   localparam int AW      = $clog2(ENTRIES);
   localparam int IW      = $clog2(DEPTH);
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int CXW     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
   localparam int NW      = 7;
   localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);

   req_payload_type req_ff;
   entry_type       mem [0:ENTRIES-1];
   entry_type       rd_ff, hold_ff, wr_data;
   logic [CW-1:0]   cnt_ff [0:NUM_CONTEXTS-1];
   logic [IW-1:0]   idx_ff, idx_in, j_ff, j_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic            ctx_ok;
   logic [CXW-1:0]  ctx_ix;
   logic [CW-1:0]   cnt_cur;
   logic [AW-1:0]   base, rd_addr, wr_addr;
   logic [NW-1:0]   cnt_w, lim_w, min_w, drain_n;
   logic [39:0]     req_key;

   assign ctx_ok  = ({30'd0, req_ff.context_req} < NUM_CONTEXTS);
   assign ctx_ix  = CXW'(req_ff.context_req);
   assign cnt_cur = ctx_ok ? cnt_ff[ctx_ix] : '0;
   assign base    = AW'(req_ff.context_req) * DEPTH_A;
   assign req_key = {req_ff.table_num, req_ff.tuple_num};

   // Number of entries a drain emits.
   assign cnt_w   = NW'(cnt_cur);
   assign lim_w   = req_ff.drain_all ? NW'(MAX_RESULTS) : NW'(req_ff.drain_count);
   assign min_w   = (cnt_w < lim_w) ? cnt_w : lim_w;
   assign drain_n = (min_w < NW'(MAX_RESULTS)) ? min_w : NW'(MAX_RESULTS);

   assign rd_addr = base + ((cmd.rd_sel == RD_JM1) ? AW'(j_ff - 1'b1) : AW'(idx_ff));
   assign wr_addr = base + ((cmd.wr_src == WR_REQ) ? AW'(cnt_cur[IW-1:0]) : AW'(j_ff));

   always_comb begin
      case (cmd.wr_src)
         WR_REQ:  wr_data = {req_ff.rec_kind, req_key, req_ff.rec_value, req_ff.slot};
         WR_RD:   wr_data = rd_ff;
         default: wr_data = hold_ff;
      endcase
   end

   always_comb begin
      case (cmd.idx_op)
         IDX_LOOK: idx_in = IW'(cnt_cur - 1'b1);
         IDX_ZERO: idx_in = '0;
         IDX_ONE:  idx_in = IW'(1);
         IDX_DEC:  idx_in = idx_ff - 1'b1;
         IDX_INC:  idx_in = idx_ff + 1'b1;
         default:  idx_in = idx_ff;
      endcase
      if (cmd.j_load) begin
         j_in = idx_ff;
      end else if (cmd.j_dec) begin
         j_in = j_ff - 1'b1;
      end else begin
         j_in = j_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CONTEXTS; c++) begin
            cnt_ff[c] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cnt_inc) begin
            cnt_ff[ctx_ix] <= cnt_cur + 1'b1;
         end else if (cmd.cnt_clr) begin
            cnt_ff[ctx_ix] <= '0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      if (cmd.hold_load) begin
         hold_ff <= rd_ff;
      end
      idx_ff <= idx_in;
      j_ff   <= j_in;
      if (cmd.rsp_load) begin
         rsp_ff.status <= cmd.rsp_status;
         rsp_ff.last   <= cmd.rsp_last;
         rsp_ff.out_value <= (cmd.rsp_status == ST_FOUND || cmd.rsp_status == ST_DRAINED)
                             ? rd_ff.value : '0;
         if (cmd.rsp_status == ST_DRAINED) begin
            rsp_ff.out_kind  <= rd_ff.kind;
            rsp_ff.out_table <= rd_ff.key[39:32];
            rsp_ff.out_tuple <= rd_ff.key[31:0];
            rsp_ff.out_slot  <= rd_ff.slot;
         end else begin
            rsp_ff.out_kind  <= '0;
            rsp_ff.out_table <= '0;
            rsp_ff.out_tuple <= '0;
            rsp_ff.out_slot  <= '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      sts.req_type    = req_ff.req_type;
      sts.ctx_ok      = ctx_ok;
      sts.full        = (cnt_cur == CW'(DEPTH));
      sts.cnt_zero    = (cnt_cur == '0);
      sts.cnt_lt2     = (cnt_cur < CW'(2));
      sts.drain_zero  = (drain_n == '0);
      sts.idx_zero    = (idx_ff == '0);
      sts.drain_last  = ((NW'(idx_ff) + 1'b1) == drain_n);
      sts.sort_last   = ((CW'(idx_ff) + 1'b1) == cnt_cur);
      sts.j_zero      = (j_ff == '0);
      sts.key_hit     = (rd_ff.key == req_key);
      sts.hit_deleted = (rd_ff.kind == KIND_DELETE);
      sts.key_gt      = (rd_ff.key > hold_ff.key);
      sts.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule
